// ----- src/lgpf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lgpf_pkg
// Shared types and constants for the lidar grazing point filter.
// ----------------------------------------------------------------------------
package lgpf_pkg;

  localparam int RANGE_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Serial multiplier geometry
  localparam int DIGIT_W   = 4;
  localparam int MCAND_W   = 48;
  localparam int MPLIER_W  = 32;
  localparam int ACC_W     = 64;
  localparam int AV_W      = 31;
  localparam int SQ_W      = 33;
  localparam int STEP_W    = 3;
  localparam int SHORT_STEPS = 4;   // 16-bit multiplier
  localparam int D2_STEPS    = 8;   // 31-bit multiplier

  localparam logic [CFG_W-1:0] COS_ONE = 16'd32768;

  // Register reset values
  localparam logic [CFG_W-1:0] COS_STEP_RST  = 16'd32768;
  localparam logic [CFG_W-1:0] COS_SQ_TH_RST = 16'd49152;
  localparam logic [CFG_W-1:0] RANGE_LO_RST  = 16'd100;
  localparam logic [CFG_W-1:0] RANGE_HI_RST  = 16'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_STEP  = 2'd0,
    CFG_COS_SQ_TH = 2'd1,
    CFG_RANGE_LO  = 2'd2,
    CFG_RANGE_HI  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_PUSH
  } flt_state_t;

  typedef enum logic [2:0] {
    SD_IDLE,
    SD_AV,
    SD_D2,
    SD_AA,
    SD_BB,
    SD_ABC,
    SD_TE,
    SD_DONE
  } side_state_t;

endpackage

`default_nettype wire

// ----- src/lgpf_side.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lgpf_side
// Grazing test for one neighbour: 2*(a*c - b*2^15)^2 > T*e with
// e = (a^2 + b^2)*2^15 - 2*a*b*c, on a digit-serial shift-add multiplier.
// ----------------------------------------------------------------------------
module lgpf_side (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lgpf_pkg::RANGE_W-1:0]  a,
  input  logic [lgpf_pkg::RANGE_W-1:0]  b,
  input  logic [lgpf_pkg::CFG_W-1:0]    c,
  input  logic [lgpf_pkg::CFG_W-1:0]    t,
  output logic                          done,
  output logic                          grazing
);
  import lgpf_pkg::*;

  side_state_t state, state_next;

  logic [RANGE_W-1:0]         a_r, b_r;
  logic [MCAND_W-1:0]         mcand;
  logic [MPLIER_W-1:0]        mplier;
  logic [ACC_W-1:0]           acc;
  logic [STEP_W-1:0]          step;
  logic [AV_W-1:0]            av;
  logic [SQ_W-1:0]            sq;
  logic [ACC_W-1:0]           lhs;

  logic [DIGIT_W-1:0]         digit;
  logic [MCAND_W+DIGIT_W-1:0] pp;
  logic [ACC_W-1:0]           acc_step;
  logic [STEP_W-1:0]          last_step;
  logic                       op_end;
  logic [AV_W-1:0]            bv, av_w, d_w;
  logic [MCAND_W-1:0]         e_w;

  // one digit of the multiplier per cycle, MSB first
  always_comb begin
    digit     = mplier[MPLIER_W-1 -: DIGIT_W];
    pp        = mcand * digit;
    acc_step  = {acc[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + ACC_W'(pp);
    last_step = (state == SD_D2) ? STEP_W'(D2_STEPS - 1) : STEP_W'(SHORT_STEPS - 1);
    av_w      = acc_step[AV_W-1:0];
    bv        = {b_r, 15'b0};
    d_w       = (av_w >= bv) ? (av_w - bv) : (bv - av_w);
    e_w       = {sq, 15'b0} - {acc_step[MCAND_W-2:0], 1'b0};
  end

  // FSM outputs
  always_comb begin
    done   = (state == SD_DONE);
    op_end = (state != SD_IDLE) && (state != SD_DONE) && (step == last_step);
  end

  // FSM next state
  always_comb begin
    state_next = state;
    case (state)
      SD_IDLE: if (start) state_next = SD_AV;
      SD_AV:   if (op_end) state_next = SD_D2;
      SD_D2:   if (op_end) state_next = SD_AA;
      SD_AA:   if (op_end) state_next = SD_BB;
      SD_BB:   if (op_end) state_next = SD_ABC;
      SD_ABC:  if (op_end) state_next = SD_TE;
      SD_TE:   if (op_end) state_next = SD_DONE;
      SD_DONE: state_next = SD_IDLE;
      default: state_next = SD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= '0;
      grazing <= 1'b0;
    end else begin
      case (state)
        SD_IDLE: begin
          if (start) begin
            a_r    <= a;
            b_r    <= b;
            mcand  <= MCAND_W'(a);
            mplier <= {c, 16'b0};
            acc    <= '0;
            step   <= '0;
          end
        end
        SD_DONE: begin
        end
        default: begin
          if (op_end) begin
            step <= '0;
            acc  <= '0;
            // finish this product, load operands of the next one
            case (state)
              SD_AV: begin
                av     <= av_w;
                mcand  <= MCAND_W'(d_w);
                mplier <= {1'b0, d_w};
              end
              SD_D2: begin
                lhs    <= {acc_step[ACC_W-2:0], 1'b0};
                mcand  <= MCAND_W'(a_r);
                mplier <= {a_r, 16'b0};
              end
              SD_AA: begin
                sq     <= acc_step[SQ_W-1:0];
                mcand  <= MCAND_W'(b_r);
                mplier <= {b_r, 16'b0};
              end
              SD_BB: begin
                sq     <= sq + SQ_W'(acc_step[SQ_W-2:0]);
                mcand  <= MCAND_W'(av);
                mplier <= {b_r, 16'b0};
              end
              SD_ABC: begin
                mcand  <= e_w;
                mplier <= {t, 16'b0};
              end
              SD_TE: begin
                grazing <= (lhs > acc_step);
              end
              default: begin
              end
            endcase
          end else begin
            acc    <= acc_step;
            mplier <= {mplier[MPLIER_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            step   <= step + STEP_W'(1);
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/lidar_grazing_point_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_grazing_point_filter
// Streaming grazing point filter for one planar lidar scan.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel (sample_valid/sample_ready, range_mm, last_sample) takes one
//   range item; result channel (result_valid/result_ready, filtered_range,
//   keep, scan_end) returns filtered items one sample late. The last sample of
//   a scan flushes the filtered previous sample, if there is one, and itself.
//   Config port (cfg_write, cfg_index, cfg_data) writes a register;
//   write only while the block is idle.
// Operation:
//   A sample with two neighbours and a nonzero centre runs both neighbour
//   tests in parallel on two digit-serial multipliers (4-bit digits): six
//   products, among them a 31-bit square, then a done state. Its result is
//   pushed from the push state, and the next sample is taken only once all
//   results of this one have entered the queue.
//   Other samples: a first one that is not final leaves no result; others
//   push theirs from the push state, a final one flushing up to two there.
// Reset: registers return to defaults, scan state and result queue clear.
// Stall: results sit in a 2-deep output queue; a new sample is taken while
//   results wait there. When the queue is full the block holds in its push
//   state and sample_ready stays low.
// ----------------------------------------------------------------------------
module lidar_grazing_point_filter (
  input  logic                            clk,
  input  logic                            rst,
  // sample channel
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  logic [lgpf_pkg::RANGE_W-1:0]    range_mm,
  input  logic                            last_sample,
  // result channel
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [lgpf_pkg::RANGE_W-1:0]    filtered_range,
  output logic                            keep,
  output logic                            scan_end,
  // config port
  input  logic                            cfg_write,
  input  logic [lgpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgpf_pkg::CFG_W-1:0]      cfg_data
);
  import lgpf_pkg::*;

  flt_state_t state, state_next;

  // config registers
  logic [CFG_W-1:0]   cos_step, cos_sq_threshold, range_lo, range_hi;
  logic [CFG_W-1:0]   c_sat;

  // scan state
  logic [RANGE_W-1:0] left_range;    // filtered previous sample
  logic [RANGE_W-1:0] centre_range;  // raw pending sample
  logic [1:0]         samples_seen;  // saturates at 2

  // results waiting to enter the queue: p0 = previous sample, p1 = final sample
  logic               p0_valid, p1_valid;
  logic [RANGE_W-1:0] p0_range, p1_range;

  // 2-deep output queue
  logic [RANGE_W-1:0] fifo_range [2];
  logic               fifo_keep  [2];
  logic               fifo_end   [2];
  logic               wr_ptr, rd_ptr;
  logic [1:0]         fifo_count;

  logic               accept, calc_start, push_now, pop;
  logic [RANGE_W-1:0] push_range;
  logic               done_l, done_r, graze_l, graze_r, side_done, reject;

  assign c_sat = (cos_step > COS_ONE) ? COS_ONE : cos_step;

  // left neighbour: filtered previous sample
  lgpf_side u_side_l (
    .clk     (clk),
    .rst     (rst),
    .start   (calc_start),
    .a       (left_range),
    .b       (centre_range),
    .c       (c_sat),
    .t       (cos_sq_threshold),
    .done    (done_l),
    .grazing (graze_l)
  );

  // right neighbour: raw incoming sample
  lgpf_side u_side_r (
    .clk     (clk),
    .rst     (rst),
    .start   (calc_start),
    .a       (range_mm),
    .b       (centre_range),
    .c       (c_sat),
    .t       (cos_sq_threshold),
    .done    (done_r),
    .grazing (graze_r)
  );

  assign side_done = done_l;
  assign reject    = graze_l & graze_r;

  // FSM outputs
  always_comb begin
    sample_ready = (state == ST_IDLE);
    accept       = sample_valid && sample_ready;
    // a zero centre passes as zero, no test needed
    calc_start   = accept && (samples_seen == 2'd2) && (centre_range != '0);
    push_now     = (state == ST_PUSH) && (p0_valid || p1_valid) && (fifo_count != 2'd2);
    push_range   = p0_valid ? p0_range : p1_range;
  end

  // FSM next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (calc_start) begin
            state_next = ST_CALC;
          end else if ((samples_seen != 2'd0) || last_sample) begin
            state_next = ST_PUSH;
          end
        end
      end
      ST_CALC: if (side_done) state_next = ST_PUSH;
      ST_PUSH: if (push_now && !(p0_valid && p1_valid)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_step         <= COS_STEP_RST;
      cos_sq_threshold <= COS_SQ_TH_RST;
      range_lo         <= RANGE_LO_RST;
      range_hi         <= RANGE_HI_RST;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COS_STEP:  cos_step         <= cfg_data;
        CFG_COS_SQ_TH: cos_sq_threshold <= cfg_data;
        CFG_RANGE_LO:  range_lo         <= cfg_data;
        CFG_RANGE_HI:  range_hi         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // scan state and pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      left_range   <= '0;
      centre_range <= '0;
      samples_seen <= 2'd0;
      p0_valid     <= 1'b0;
      p1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        p0_valid <= (samples_seen != 2'd0);
        p0_range <= centre_range;
        p1_valid <= last_sample;
        p1_range <= range_mm;
        if (last_sample) begin
          left_range   <= '0;
          centre_range <= '0;
          samples_seen <= 2'd0;
        end else begin
          centre_range <= range_mm;
          if (samples_seen != 2'd2) samples_seen <= samples_seen + 2'd1;
          // second sample, or a zero centre: previous result is the raw centre
          if ((samples_seen != 2'd0) && !calc_start) left_range <= centre_range;
        end
      end
      if (side_done) begin
        if (reject) p0_range <= '0;
        // scan already closed by its final sample: keep the cleared state
        left_range <= (p1_valid || reject) ? '0 : p0_range;
      end
      if (push_now) begin
        if (p0_valid) begin
          p0_valid <= 1'b0;
        end else begin
          p1_valid <= 1'b0;
        end
      end
    end
  end

  // output queue
  assign pop = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (push_now) begin
      fifo_range[wr_ptr] <= push_range;
      fifo_keep[wr_ptr]  <= (push_range >= range_lo) && (push_range <= range_hi);
      fifo_end[wr_ptr]   <= !p0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      fifo_count <= 2'd0;
    end else begin
      if (push_now) wr_ptr <= ~wr_ptr;
      if (pop)      rd_ptr <= ~rd_ptr;
      fifo_count <= fifo_count + {1'b0, push_now} - {1'b0, pop};
    end
  end

  assign result_valid   = (fifo_count != 2'd0);
  assign filtered_range = fifo_range[rd_ptr];
  assign keep           = fifo_keep[rd_ptr];
  assign scan_end       = fifo_end[rd_ptr];

`ifndef SYNTHESIS
  // both neighbour tests run in lockstep
  a_sides_lockstep: assert property (@(posedge clk) disable iff (rst)
    done_l == done_r)
    else $error("neighbour tests out of step");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= 2'd2)
    else $error("result queue overflow");

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    side_done |-> (state == ST_CALC))
    else $error("neighbour test finished outside calc");

  a_scan_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && last_sample) |=> (samples_seen == 2'd0) && (centre_range == '0))
    else $error("scan state not cleared after final sample");
`endif

endmodule

`default_nettype wire

// ----- tb/lidar_grazing_point_filter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_grazing_point_filter_tb
// Self-checking bench for the lidar grazing point filter. Scans of range
// samples go in through the sample channel; each accepted sample is run
// through a bit-exact model of the filter. The model gives the filtered
// range, keep flag and scan end flag that each result must carry. Register
// settings change between scans, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module lidar_grazing_point_filter_tb;
  import lgpf_pkg::*;

  // Settle time after the last result of a phase, long enough to cover a
  // sample that is still in flight.
  localparam int SETTLE_CYCLES = 48;
  // Long receiver hold that fills the output queue and stalls the input.
  localparam int HOLD_CYCLES   = 400;
  // Quiet-cycle limit. The longest quiet stretch of a correct run is the
  // receiver hold, plus one item's work and both sides' worst gaps, or a
  // phase drain and register writes. Several times over that.
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 1900;

  typedef struct packed {
    logic [RANGE_W-1:0] rng;
    logic               keep;
    logic               scan_end;
  } filtered_pt_t;

  // --------------------------------------------------------------------------
  // Filter model and result checker
  // --------------------------------------------------------------------------
  class grazing_scoreboard;
    bit [CFG_W-1:0]   cos_step;
    bit [CFG_W-1:0]   cos_sq_th;
    bit [CFG_W-1:0]   lo_rng;
    bit [CFG_W-1:0]   hi_rng;
    // scan state: filtered left neighbor, raw pending centre, samples seen
    bit [RANGE_W-1:0] prev_filtered;
    bit [RANGE_W-1:0] pending_raw;
    int unsigned      seen;
    filtered_pt_t     expected_points[$];
    int unsigned      mismatches;
    int unsigned      results_checked;
    int unsigned      samples_noted;
    int unsigned      scans_noted;
    int unsigned      zeroed;
    int unsigned      kept;

    function new();
      cos_step        = COS_STEP_RST;
      cos_sq_th       = COS_SQ_TH_RST;
      lo_rng          = RANGE_LO_RST;
      hi_rng          = RANGE_HI_RST;
      prev_filtered   = '0;
      pending_raw     = '0;
      seen            = 0;
      mismatches      = 0;
      results_checked = 0;
      samples_noted   = 0;
      scans_noted     = 0;
      zeroed          = 0;
      kept            = 0;
    endfunction

    // Exact side test: 2*(a*c - b<<15)^2 > T*((a^2 + b^2)<<15 - 2abc).
    // Everything fits in 64 bits unsigned.
    function bit is_grazing(bit [RANGE_W-1:0] nbr, bit [RANGE_W-1:0] ctr);
      bit [63:0] a, b, c, av, bv, d, lhs, e, rhs;
      a   = 64'(nbr);
      b   = 64'(ctr);
      c   = 64'((cos_step > COS_ONE) ? COS_ONE : cos_step);   // saturate at one
      av  = a * c;
      bv  = b << 15;
      d   = (av >= bv) ? av - bv : bv - av;
      lhs = (d * d) << 1;
      e   = ((a * a + b * b) << 15) - 64'd2 * a * b * c;
      rhs = 64'(cos_sq_th) * e;
      return lhs > rhs;
    endfunction

    function void push_point(bit [RANGE_W-1:0] r, bit last);
      filtered_pt_t p;
      p.rng      = r;
      p.keep     = (r >= lo_rng) && (r <= hi_rng);
      p.scan_end = last;
      if (p.keep) kept++;
      expected_points.insert(expected_points.size(), p);
    endfunction

    // One accepted sample: releases the pending sample (filtered if it is
    // interior), and on the last sample of a scan also the sample itself.
    function void note_sample(bit [RANGE_W-1:0] x, bit last);
      bit [RANGE_W-1:0] r;
      samples_noted++;
      if (seen == 1) begin
        // first sample of a scan passes unchanged
        push_point(pending_raw, 1'b0);
        prev_filtered = pending_raw;
      end else if (seen >= 2) begin
        r = pending_raw;
        if (r != 0 && is_grazing(prev_filtered, r) && is_grazing(x, r)) begin
          r = '0;
          zeroed++;
        end
        push_point(r, 1'b0);
        prev_filtered = r;
      end
      if (last) begin
        push_point(x, 1'b1);
        prev_filtered = '0;
        pending_raw   = '0;
        seen          = 0;
        scans_noted++;
      end else begin
        pending_raw = x;
        if (seen < 2) seen++;
      end
    endfunction

    function void check_result(logic [RANGE_W-1:0] rng, logic kp, logic se);
      filtered_pt_t want;
      results_checked++;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: range=%0d keep=%b scan_end=%b",
                   $realtime, rng, kp, se);
        return;
      end
      want = expected_points.pop_front();
      if (rng !== want.rng || kp !== want.keep || se !== want.scan_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] result %0d mismatch: exp range=%0d keep=%b end=%b,",
                    " got range=%0d keep=%b end=%b"},
                   $realtime, results_checked, want.rng, want.keep, want.scan_end,
                   rng, kp, se);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, block
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst            = 1'b1;
  logic                 sample_valid   = 1'b0;
  logic                 sample_ready;
  logic [RANGE_W-1:0]   range_mm       = '0;
  logic                 last_sample    = 1'b0;
  logic                 result_valid;
  logic                 result_ready   = 1'b0;
  logic [RANGE_W-1:0]   filtered_range;
  logic                 keep;
  logic                 scan_end;
  logic                 cfg_write      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = CFG_COS_STEP;
  logic [CFG_W-1:0]     cfg_data       = '0;

  grazing_scoreboard sb;

  // per-phase idle bounds for each side, and the one-shot long hold request
  int send_idle_max = 0;
  int recv_idle_max = 0;
  bit hold_req      = 1'b0;
  int n_settings    = 0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  lidar_grazing_point_filter DUT (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .range_mm       (range_mm),
    .last_sample    (last_sample),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .filtered_range (filtered_range),
    .keep           (keep),
    .scan_end       (scan_end),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------
  // Offers one item after a random gap. Valid is left high on return, so a
  // back-to-back item keeps it high; the caller drops it at the end of a phase.
  task automatic send_sample(input logic [RANGE_W-1:0] r, input logic last);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    range_mm     <= r;
    last_sample  <= last;
    do @(posedge clk); while (!sample_ready);
    sb.note_sample(r, last);
  endtask

  // One scan. Styles: 0 smooth wall with dropouts, 1 steady ramp (grazing
  // prone), 2 full random, 3 extremes and zeros.
  task automatic run_scan(input int len, input int style);
    int walk, v, k, dir, sel;
    walk = $urandom_range(100, 12000);
    dir  = $urandom_range(0, 1) ? 1 : -1;
    for (k = 0; k < len; k++) begin
      case (style)
        0: begin
          walk += int'($urandom_range(0, 400)) - 200;
          v = ($urandom_range(0, 9) == 0) ? 0 : walk;
        end
        1: begin
          walk += dir * int'($urandom_range(0, 2500));
          v = walk;
        end
        2: v = $urandom_range(0, 65535);
        default: begin
          sel = $urandom_range(0, 4);
          if (sel == 0)      v = 0;
          else if (sel == 1) v = 1;
          else if (sel == 2) v = 65535;
          else if (sel == 3) v = 65534;
          else               v = $urandom_range(0, 65535);
        end
      endcase
      if (walk < 0) walk = 0;
      if (walk > 65535) walk = 65535;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      send_sample(v[RANGE_W-1:0], k == len - 1);
    end
  endtask

  // Drop valid, wait for every expected result, then let any sample that
  // causes no result finish inside the block.
  task automatic finish_phase();
    sample_valid <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All four registers, one per cycle; model copy follows.
  task automatic write_regs(input logic [CFG_W-1:0] cs, input logic [CFG_W-1:0] th,
                            input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    cfg_write <= 1'b1;
    cfg_index <= CFG_COS_STEP;
    cfg_data  <= cs;
    @(posedge clk);
    cfg_index <= CFG_COS_SQ_TH;
    cfg_data  <= th;
    @(posedge clk);
    cfg_index <= CFG_RANGE_LO;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_RANGE_HI;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_write    <= 1'b0;
    sb.cos_step  = cs;
    sb.cos_sq_th = th;
    sb.lo_rng    = lo;
    sb.hi_rng    = hi;
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall after each item, one long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    result_ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(result_valid && result_ready));
      sb.check_result(filtered_range, keep, scan_end);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, recv_idle_max);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        result_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no item moving on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase, n_scans, s, len, style, mode;
    logic [CFG_W-1:0] cs, th, lo, hi;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset register values (step of zero, 30 degree threshold).
    send_sample(16'd5000, 1'b1);            // single-sample scan
    send_sample(16'd1000, 1'b0);            // equal ranges at zero step: kept
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1000, 1'b1);
    send_sample(16'd1000, 1'b0);            // ramp along the ray: zeroed,
    send_sample(16'd2000, 1'b0);            // then a zeroed left neighbor
    send_sample(16'd3000, 1'b0);
    send_sample(16'd4000, 1'b1);
    send_sample(16'd0,     1'b0);           // zero neighbors and centres,
    send_sample(16'd3000,  1'b0);           // range extremes, keep bounds
    send_sample(16'd0,     1'b0);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd50,    1'b0);
    send_sample(16'd20000, 1'b1);
    finish_phase();

    // cos above one saturates; full keep window so a zero range is kept
    write_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    send_sample(16'd0,   1'b0);
    send_sample(16'd500, 1'b0);
    send_sample(16'd0,   1'b1);
    send_sample(16'd7,   1'b0);             // two-sample scan
    send_sample(16'd9,   1'b1);
    finish_phase();

    // right-angle step, zero threshold, empty keep window
    write_regs(16'd0, 16'd0, 16'hFFFF, 16'd0);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd1,     1'b0);
    send_sample(16'd65535, 1'b1);
    finish_phase();

    // Random phases: new registers, idle pattern and a handful of scans each.
    phase = 0;
    while (sb.samples_noted < RANDOM_ITEMS + 24) begin
      if (phase == 0) begin
        cs = '0;      th = '0;      lo = '0;      hi = '0;
      end else if (phase == 1) begin
        cs = 16'hFFFF; th = 16'hFFFF; lo = 16'hFFFF; hi = 16'hFFFF;
      end else if (phase == 2) begin
        cs = COS_STEP_RST; th = COS_SQ_TH_RST; lo = RANGE_LO_RST; hi = RANGE_HI_RST;
      end else begin
        case ($urandom_range(0, 7))
          0: cs = COS_ONE;
          1: cs = 16'd0;
          2: cs = 16'hFFFF;
          3: cs = 16'd32763;                // about one degree
          4: cs = 16'd32700;
          5: cs = CFG_W'($urandom_range(30000, 32768));
          6: cs = CFG_W'($urandom_range(0, 65535));
          default: cs = CFG_W'($urandom_range(0, 32768));
        endcase
        case ($urandom_range(0, 4))
          0: th = COS_SQ_TH_RST;
          1: th = 16'd0;
          2: th = 16'hFFFF;
          3: th = CFG_W'($urandom_range(0, 65535));
          default: th = CFG_W'($urandom_range(40000, 60000));
        endcase
        case ($urandom_range(0, 3))
          0: lo = 16'd0;
          1: lo = RANGE_LO_RST;
          2: lo = 16'hFFFF;
          default: lo = CFG_W'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 3))
          0: hi = 16'hFFFF;
          1: hi = RANGE_HI_RST;
          2: hi = 16'd0;
          default: hi = CFG_W'($urandom_range(0, 65535));
        endcase
      end
      write_regs(cs, th, lo, hi);

      // idle pattern: none, both sides, receiver only, sender only
      mode = (phase == 3) ? 0 : $urandom_range(0, 3);
      send_idle_max = (mode == 1 || mode == 3) ? 12 : 0;
      recv_idle_max = (mode == 1 || mode == 2) ? 12 : 0;
      // back-pressure phase: receiver holds while samples keep coming
      if (phase == 3) hold_req = 1'b1;

      n_scans = $urandom_range(4, 8);
      for (s = 0; s < n_scans; s++) begin
        case ($urandom_range(0, 9))
          0:       len = 1;
          1:       len = $urandom_range(40, 64);
          default: len = $urandom_range(2, 25);
        endcase
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6:     style = 0;
          7, 8, 9, 10, 11, 12, 13: style = 1;
          14, 15, 16:              style = 2;
          default:                 style = 3;
        endcase
        run_scan(len, style);
      end
      finish_phase();
      phase++;
    end

    $display("Ran %0d samples in %0d scans under %0d register settings.",
             sb.samples_noted, sb.scans_noted, n_settings + 1);
    $display("Checked %0d results: %0d grazing points zeroed, %0d flagged keep.",
             sb.results_checked, sb.zeroed, sb.kept);
    if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
